// ----- design/crs_pkg.sv -----
// ----------------------------------------------------------------------------
// crs_pkg
// Shared constants, codes and types of the circle ring alpha stamper.
// ----------------------------------------------------------------------------
package crs_pkg;

  localparam int unsigned ROW_PAIRS_DEF = 152;
  localparam int unsigned GRID_ROWS_DEF = 240;

  localparam int unsigned CLAMP_A = 75;
  localparam int unsigned CLAMP_B = 111;
  localparam int unsigned CLAMP_C = 110;

  localparam logic OP_STAMP = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic MODE_HIDE = 1'b0;
  localparam logic MODE_SHOW = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TOUCH,
    ST_DONE,
    ST_READ,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [7:0] cx;
    logic [7:0] cy;
    logic [6:0] dc;
    logic [6:0] dr;
  } point_t;

  typedef struct packed {
    logic row_below;
    logic neg_row;
    logic neg_col;
  } sel_t;

endpackage

// ----- design/crs_touch_unit.sv -----
// ----------------------------------------------------------------------------
// crs_touch_unit
// Shared point unit: offsets a centre, checks the map bounds and forms the
// bit address of the touched pixel.
// ----------------------------------------------------------------------------
module crs_touch_unit #(
  parameter int unsigned ROW_PAIRS = crs_pkg::ROW_PAIRS_DEF,
  parameter int unsigned GRID_ROWS = crs_pkg::GRID_ROWS_DEF,
  parameter int unsigned AW        = 16
) (
  input  crs_pkg::point_t pt_i,
  input  crs_pkg::sel_t   sel_i,
  output logic            in_map_o,
  output logic [AW-1:0]   addr_o
);
  import crs_pkg::*;

  logic [10:0] col;
  logic [10:0] row;
  logic [10:0] row_pt;

  always_comb begin
    col    = sel_i.neg_col ? (11'(pt_i.cx) - 11'(pt_i.dc)) : (11'(pt_i.cx) + 11'(pt_i.dc));
    row_pt = sel_i.neg_row ? (11'(pt_i.cy) - 11'(pt_i.dr)) : (11'(pt_i.cy) + 11'(pt_i.dr));
    row    = row_pt + 11'(sel_i.row_below);
    // bit 10 marks a negative coordinate
    in_map_o = !col[10] && !row[10] && (col < 11'(ROW_PAIRS)) && (row < 11'(GRID_ROWS));
    addr_o   = AW'(row[8:0]) * AW'(ROW_PAIRS) + AW'(col[8:0]);
  end

endmodule

// ----- design/crs_alpha_ram.sv -----
// ----------------------------------------------------------------------------
// crs_alpha_ram
// One-bit alpha map memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module crs_alpha_ram #(
  parameter int unsigned DEPTH = 36480,
  parameter int unsigned AW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wbit_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rbit_o
);

  logic mem_q [DEPTH];
  logic rd_bit_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wbit_i;
    end
    rd_bit_q <= mem_q[raddr_i];
  end

  assign rbit_o = rd_bit_q;

endmodule

// ----- design/circle_ring_alpha_stamper.sv -----
// ----------------------------------------------------------------------------
// circle_ring_alpha_stamper
// Midpoint circle ring stamper over a one-bit alpha map, with alpha reads.
// ----------------------------------------------------------------------------
// A stamp walks the ring in the touch state, each walk step touching
//   eight mirrored points and the row below each, then passes the done state;
//   a read passes the read and response states; each result is registered
// throughput: one item at a time; the next transfer waits for the result slot to free
// reset: the map is cleared one bit a cycle, all ROW_PAIRS * GRID_ROWS bits
//   (36480 by default), and no item is taken until that is done
module circle_ring_alpha_stamper #(
  parameter int unsigned ROW_PAIRS = crs_pkg::ROW_PAIRS_DEF,
  parameter int unsigned GRID_ROWS = crs_pkg::GRID_ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // center_col, center_row, radius, read_col, read_row
  input  logic [39:0] s_axis_tdata_i,
  // op
  input  logic [0:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // alpha_bit, zero fill
  output logic [7:0]  m_axis_tdata_o,
  // was_stamp
  output logic [0:0]  m_axis_tuser_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_data_i
);
  import crs_pkg::*;

  localparam int unsigned DEPTH = ROW_PAIRS * GRID_ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);

  state_e state_q, state_d;

  logic [3:0]    t_q, t_d;
  logic [9:0]    i_q, i_d, j_q, j_d;
  logic [11:0]   d_q, d_d;
  logic [7:0]    cx_q, cx_d, cy_q, cy_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          mode_q;
  logic          wr_en_q, wr_en_d, wr_bit_q, wr_bit_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d, rd_addr_q, rd_addr_d;
  logic          rd_inb_q, rd_inb_d;
  logic          out_valid_q, out_valid_d, out_alpha_q, out_alpha_d, out_stamp_q, out_stamp_d;

  logic          in_xfer;
  logic          in_op;
  logic [7:0]    f_ccol, f_crow, f_rad, f_rcol, f_rrow;
  logic          slot_free;
  logic          last_touch;

  point_t        pt;
  sel_t          sel;
  logic          u_in_map;
  logic [AW-1:0] u_addr;
  logic          ram_bit;

  logic [6:0]    j75, j110, i75, i111;
  logic [11:0]   d1, d_corr;
  logic [9:0]    i_n, j_m1, j_n;
  logic          walk_more;

  assign f_ccol = s_axis_tdata_i[7:0];
  assign f_crow = s_axis_tdata_i[15:8];
  assign f_rad  = s_axis_tdata_i[23:16];
  assign f_rcol = s_axis_tdata_i[31:24];
  assign f_rrow = s_axis_tdata_i[39:32];
  assign in_op  = s_axis_tuser_i[0];

  assign slot_free       = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && slot_free;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign last_touch      = (t_q == 4'd15);

  // clamped offsets
  always_comb begin
    j75  = (j_q > 10'(CLAMP_A)) ? 7'(CLAMP_A) : j_q[6:0];
    j110 = (j_q > 10'(CLAMP_C)) ? 7'(CLAMP_C) : j_q[6:0];
    i75  = (i_q > 10'(CLAMP_A)) ? 7'(CLAMP_A) : i_q[6:0];
    i111 = (i_q > 10'(CLAMP_B)) ? 7'(CLAMP_B) : i_q[6:0];
  end

  // midpoint decision update
  always_comb begin
    i_n       = i_q + 10'd1;
    j_m1      = j_q - 10'd1;
    d1        = d_q - 12'd1 - {1'b0, i_q, 1'b0};
    d_corr    = d1 + {j_m1[9], j_m1, 1'b0};
    j_n       = d1[11] ? j_m1 : j_q;
    walk_more = $signed(i_n) <= $signed(j_n);
  end

  // shared unit operands
  always_comb begin
    if (state_q == ST_TOUCH) begin
      pt.cx = cx_q;
      pt.cy = cy_q;
      pt.dc = t_q[3] ? i75 : j75;
      pt.dr = t_q[3] ? j110 : i111;
      sel.neg_col   = t_q[2];
      sel.neg_row   = t_q[1];
      sel.row_below = t_q[0];
    end else begin
      pt.cx = f_rcol;
      pt.cy = f_rrow;
      pt.dc = '0;
      pt.dr = '0;
      sel   = '0;
    end
  end

  crs_touch_unit #(
    .ROW_PAIRS (ROW_PAIRS),
    .GRID_ROWS (GRID_ROWS),
    .AW        (AW)
  ) u_touch (
    .pt_i     (pt),
    .sel_i    (sel),
    .in_map_o (u_in_map),
    .addr_o   (u_addr)
  );

  crs_alpha_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en_q),
    .waddr_i (wr_addr_q),
    .wbit_i  (wr_bit_q),
    .raddr_i (rd_addr_q),
    .rbit_o  (ram_bit)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) state_d = (in_op == OP_READ) ? ST_READ : ST_TOUCH;
      end
      ST_TOUCH: begin
        if (last_touch && !walk_more) state_d = ST_DONE;
      end
      ST_DONE:  state_d = ST_IDLE;
      ST_READ:  state_d = ST_RESP;
      ST_RESP:  state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // datapath and outputs
  always_comb begin
    t_d         = t_q;
    i_d         = i_q;
    j_d         = j_q;
    d_d         = d_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    clr_d       = clr_q;
    wr_en_d     = 1'b0;
    wr_addr_d   = u_addr;
    wr_bit_d    = mode_q;
    rd_addr_d   = rd_addr_q;
    rd_inb_d    = rd_inb_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_alpha_d = out_alpha_q;
    out_stamp_d = out_stamp_q;
    case (state_q)
      ST_CLEAR: begin
        wr_en_d   = 1'b1;
        wr_addr_d = clr_q;
        wr_bit_d  = MODE_HIDE;
        clr_d     = clr_q + AW'(1);
      end
      ST_IDLE: begin
        if (in_xfer) begin
          t_d       = '0;
          i_d       = '0;
          j_d       = 10'(f_rad);
          d_d       = 12'(f_rad);
          cx_d      = f_ccol;
          cy_d      = f_crow;
          rd_addr_d = u_addr;
          rd_inb_d  = u_in_map;
        end
      end
      ST_TOUCH: begin
        wr_en_d = u_in_map;
        t_d     = t_q + 4'd1;
        if (last_touch) begin
          i_d = i_n;
          j_d = j_n;
          d_d = d1[11] ? d_corr : d1;
        end
      end
      ST_DONE: begin
        out_valid_d = 1'b1;
        out_alpha_d = 1'b0;
        out_stamp_d = 1'b1;
      end
      ST_READ: begin
      end
      ST_RESP: begin
        out_valid_d = 1'b1;
        out_alpha_d = ram_bit && rd_inb_q;
        out_stamp_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      mode_q      <= MODE_HIDE;
      wr_en_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      wr_en_q     <= wr_en_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q         <= t_d;
    i_q         <= i_d;
    j_q         <= j_d;
    d_q         <= d_d;
    cx_q        <= cx_d;
    cy_q        <= cy_d;
    wr_addr_q   <= wr_addr_d;
    wr_bit_q    <= wr_bit_d;
    rd_addr_q   <= rd_addr_d;
    rd_inb_q    <= rd_inb_d;
    out_alpha_q <= out_alpha_d;
    out_stamp_q <= out_stamp_d;
  end

  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_alpha_q};
  assign m_axis_tuser_o  = out_stamp_q;

  // a stamp transfer starts the walk at its first touch
  a_stamp_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_op == OP_STAMP) |=> (state_q == ST_TOUCH && t_q == 4'd0 && i_q == 10'd0))
    else $error("stamp did not start its walk");

  // every map write lands inside the map
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_q |-> (wr_addr_q < AW'(DEPTH - 1) || wr_addr_q == AW'(DEPTH - 1)))
    else $error("map write beyond the map");

  // a read result always follows its response cycle and never claims a stamp
  a_read_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP) |=> (out_valid_q && !out_stamp_q))
    else $error("read result missing");

  // nothing is taken while the clearing pass runs
  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready_o)
    else $error("item taken during clearing pass");

endmodule

// ----- dv/crs_alpha_checker.sv -----
// ----------------------------------------------------------------------------
// crs_alpha_checker
// Watches the item, result and mode channels of the circle ring alpha stamper.
// Keeps its own alpha map and stamp mode, walks each stamped ring as the block
// should, queues the reply owed for every item and compares each reply taken
// from the block, field by field, against the oldest one owed.
// ----------------------------------------------------------------------------
module crs_alpha_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  // center_col, center_row, radius, read_col, read_row
  input  logic [39:0] s_axis_tdata_i,
  // op
  input  logic [0:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  // alpha_bit, zero fill
  input  logic [7:0]  m_axis_tdata_i,
  // was_stamp
  input  logic [0:0]  m_axis_tuser_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [0:0]  cfg_data_i,
  output int          mismatches_o,
  output int          replies_owed_o
);

  import crs_pkg::*;

  localparam int NCOL = ROW_PAIRS_DEF;
  localparam int NROW = GRID_ROWS_DEF;

  typedef struct packed {
    logic alpha_bit;
    logic was_stamp;
  } alpha_reply_t;

  bit           alpha_q [NCOL*NROW];
  logic         show_q = MODE_HIDE;
  alpha_reply_t owed_q [$];
  int           cycle_q = 0;

  initial mismatches_o = 0;
  initial replies_owed_o = 0;

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d, want %0d", cycle_q, what, got, want);
    mismatches_o++;
  endtask

  // one touch covers four mirrored points, each with the row below
  function automatic void paint_quad(input int cx, input int cy, input int dc, input int dr);
    int col;
    int row;
    for (int sc = -1; sc <= 1; sc += 2) begin
      for (int sr = -1; sr <= 1; sr += 2) begin
        for (int below = 0; below <= 1; below++) begin
          col = cx + sc * dc;
          row = cy + sr * dr + below;
          if (col >= 0 && col < NCOL && row >= 0 && row < NROW) begin
            alpha_q[row * NCOL + col] = show_q;
          end
        end
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    alpha_reply_t want;
    int i;
    int j;
    int d;
    int cx;
    int cy;
    int col;
    int row;
    if (!rst_ni) begin
      foreach (alpha_q[k]) alpha_q[k] = 1'b0;
      show_q = MODE_HIDE;
      owed_q.delete();
      replies_owed_o <= 0;
    end else begin
      cycle_q++;
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (owed_q.size() == 0) begin
          note_mismatch("reply with none owed, was_stamp", int'(m_axis_tuser_i[0]), 0);
        end else begin
          want = owed_q.pop_front();
          if (m_axis_tdata_i[0] !== want.alpha_bit) begin
            note_mismatch("alpha_bit", int'(m_axis_tdata_i[0]), int'(want.alpha_bit));
          end
          if (m_axis_tuser_i[0] !== want.was_stamp) begin
            note_mismatch("was_stamp", int'(m_axis_tuser_i[0]), int'(want.was_stamp));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        show_q = cfg_data_i[0];
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tuser_i[0] == OP_STAMP) begin
          cx = int'(s_axis_tdata_i[7:0]);
          cy = int'(s_axis_tdata_i[15:8]);
          i = 0;
          j = int'(s_axis_tdata_i[23:16]);
          d = j;
          while (i <= j) begin
            paint_quad(cx, cy, (j > CLAMP_A) ? CLAMP_A : j, (i > CLAMP_B) ? CLAMP_B : i);
            paint_quad(cx, cy, (i > CLAMP_A) ? CLAMP_A : i, (j > CLAMP_C) ? CLAMP_C : j);
            d = d - 1 - 2 * i;
            if (d < 0) begin
              d += 2 * (j - 1);
              j--;
            end
            i++;
          end
          want.alpha_bit = 1'b0;
          want.was_stamp = 1'b1;
        end else begin
          col = int'(s_axis_tdata_i[31:24]);
          row = int'(s_axis_tdata_i[39:32]);
          want.alpha_bit = (col < NCOL && row < NROW) ? alpha_q[row * NCOL + col] : 1'b0;
          want.was_stamp = 1'b0;
        end
        owed_q.push_back(want);
      end
      replies_owed_o <= owed_q.size();
    end
  end

endmodule

// ----- dv/tb_circle_ring_alpha_stamper.sv -----
// ----------------------------------------------------------------------------
// tb_circle_ring_alpha_stamper
// Drives stamp and read items into the circle ring alpha stamper under both
// stamp modes: a directed set around the map edges and the radius clamps,
// then random rings mixed with reads aimed at the latest ring and random reads,
// with random idling on both channels and one long result back-pressure stretch.
// The checker beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module tb_circle_ring_alpha_stamper;

  import crs_pkg::*;

  localparam int CYCLE_LIMIT = 8000000;
  localparam int PHASE_ITEMS = 140;
  localparam int HOLD_AT     = 80;
  localparam int HOLD_CYCLES = 500;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_data = '0;

  int mismatches;
  int replies_owed;
  int cycle_cnt = 0;
  int items_sent = 0;
  bit calm = 1'b0;
  int lcx = 76;
  int lcy = 120;
  int lr = 0;

  circle_ring_alpha_stamper DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  crs_alpha_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .mismatches_o    (mismatches),
    .replies_owed_o  (replies_owed)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // result side: short random stalls, one long hold-off, none at the tail
  initial begin : sink
    int gap;
    bit held;
    gap = 0;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && items_sent >= HOLD_AT) begin
        held = 1'b1;
        gap = HOLD_CYCLES;
      end else if (gap == 0 && !calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 11);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        gap--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic offer_item(input logic op, input logic [39:0] fields);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= fields;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic stamp_at(input logic [7:0] cc, input logic [7:0] cr, input logic [7:0] rad);
    lcx = int'(cc);
    lcy = int'(cr);
    lr  = int'(rad);
    offer_item(OP_STAMP, {8'($urandom), 8'($urandom), rad, cr, cc});
  endtask

  task automatic read_at(input logic [7:0] rc, input logic [7:0] rr);
    offer_item(OP_READ, {rr, rc, 8'($urandom), 8'($urandom), 8'($urandom)});
  endtask

  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (replies_owed != 0);
  endtask

  initial begin : stimulus
    int n;
    int pick;
    int col;
    int row;
    int reach;
    logic [7:0] cc;
    logic [7:0] cr;
    logic [7:0] rad;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // edges of the map, radius zero, and the offset clamps
    write_mode(MODE_SHOW);
    read_at(8'd0, 8'd0);
    read_at(8'd151, 8'd239);
    read_at(8'd255, 8'd17);
    read_at(8'd9, 8'd255);
    stamp_at(8'd76, 8'd120, 8'd0);
    read_at(8'd76, 8'd120);
    read_at(8'd76, 8'd121);
    stamp_at(8'd0, 8'd0, 8'd5);
    read_at(8'd5, 8'd0);
    read_at(8'd0, 8'd5);
    stamp_at(8'd151, 8'd239, 8'd3);
    read_at(8'd148, 8'd239);
    read_at(8'd151, 8'd236);
    stamp_at(8'd76, 8'd120, 8'd255);
    read_at(8'd151, 8'd120);
    read_at(8'd1, 8'd120);
    read_at(8'd76, 8'd230);
    read_at(8'd76, 8'd10);
    drain_replies();
    write_mode(MODE_HIDE);
    stamp_at(8'd76, 8'd120, 8'd255);
    read_at(8'd151, 8'd120);
    read_at(8'd76, 8'd231);

    for (int phase = 0; phase < 4; phase++) begin
      drain_replies();
      write_mode((phase == 3) ? logic'($urandom_range(0, 1)) : ((phase % 2 == 0) ? MODE_SHOW
                                                                               : MODE_HIDE));
      n = 0;
      while (n < PHASE_ITEMS) begin
        if (phase == 3 && n >= PHASE_ITEMS - 70) calm = 1'b1;
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          pick = $urandom_range(0, 99);
          rad = 8'((pick < 80) ? $urandom_range(0, 48)
                 : (pick < 95) ? $urandom_range(49, 160) : $urandom_range(161, 255));
          cc = 8'(($urandom_range(0, 49) == 0) ? $urandom_range(152, 255)
                                                : $urandom_range(0, 151));
          cr = 8'(($urandom_range(0, 49) == 0) ? $urandom_range(240, 255)
                                                : $urandom_range(0, 239));
          stamp_at(cc, cr, rad);
        end else if (pick < 9) begin
          // aim at the ring just stamped, near one of its four flat sides
          if ($urandom_range(0, 1)) begin
            reach = (lr > CLAMP_A) ? CLAMP_A : lr;
            col = lcx + ($urandom_range(0, 1) ? reach : -reach) + $urandom_range(0, 2) - 1;
            row = lcy + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(0, lr / 3)
                + $urandom_range(0, 1);
          end else begin
            reach = (lr > CLAMP_C) ? CLAMP_C : lr;
            col = lcx + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(0, lr / 4);
            row = lcy + ($urandom_range(0, 1) ? reach : -reach) + $urandom_range(0, 2) - 1;
          end
          read_at(col[7:0], row[7:0]);
        end else begin
          read_at(8'($urandom), 8'($urandom));
        end
        n++;
      end
    end

    drain_replies();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/crs_pkg.sv
design/crs_touch_unit.sv
design/crs_alpha_ram.sv
design/circle_ring_alpha_stamper.sv
dv/crs_alpha_checker.sv
dv/tb_circle_ring_alpha_stamper.sv
